// ----- rtl/kvst_pkg.sv -----
// Shared types and codes for the key/value slot table.
// No dependencies; imported by kvst_cell, key_value_slot_table_top and the testbench.
package kvst_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 64;
  localparam int SLOT_W   = 5;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_RMV = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic cmp_en;     // capture compare flags against the request key
    logic want_free;  // request claims the lowest free slot
    logic want_hit;   // request claims the lowest matching valid slot
    logic do_write;   // commit: fill the claimed slot
    logic do_clear;   // commit: free the claimed slot
  } cell_cmd_t;

endpackage

// ----- rtl/kvst_cell.sv -----
// One slot of the key/value table: valid mark, key, value and compare flags.
// Depends on kvst_pkg; chained through claim_in/claim_out by the top level.
module kvst_cell import kvst_pkg::*; #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_cmd_t             cmd,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [VALUE_BITS-1:0] req_value,
  input  logic                  claim_in,
  output logic                  claim_out,
  output logic                  sel,
  output logic                  valid_q,
  output logic [VALUE_BITS-1:0] value_q
);

  logic                  valid_r, valid_nxt;
  logic                  hit_r, hit_nxt;
  logic                  free_r, free_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  want;

  assign want      = (cmd.want_free & free_r) | (cmd.want_hit & hit_r);
  // a lower slot already took the transaction when claim_in is high
  assign sel       = want & ~claim_in;
  assign claim_out = claim_in | want;
  assign valid_q   = valid_r;
  assign value_q   = value_r;

  always_comb begin
    hit_nxt   = hit_r;
    free_nxt  = free_r;
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (cmd.cmp_en) begin
      hit_nxt  = valid_r && (key_r == req_key);
      free_nxt = ~valid_r;
    end
    if (cmd.do_write && sel) begin
      valid_nxt = 1'b1;
      key_nxt   = req_key;
      value_nxt = req_value;
    end
    if (cmd.do_clear && sel) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// ----- rtl/key_value_slot_table_top.sv -----
// Key/value slot table: a row of ENTRIES slot cells, each comparing its own key,
// joined by a claim chain that picks the lowest-index slot. Depends on kvst_pkg, kvst_cell.
//
// Each transaction passes through a compare phase, in which every cell compares the
// request key with its stored key in parallel, and a result phase, in which the claim
// chain running from slot 0 upward picks the lowest matching (or free) slot, the slot is
// written or freed and the result is loaded into the output register. The next
// transaction is accepted in the result phase, so while the output is taken a new
// transaction enters as the last one commits. A result still held by out_stall holds
// the result phase, and with it the input. Reset frees every slot at once; stored keys
// and values are not cleared and are only read from valid slots.
module key_value_slot_table_top import kvst_pkg::*; #(
  parameter int ENTRIES    = 32,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [DATA_W-1:0]   in_key,
  input  logic [DATA_W-1:0]   in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_read_value,
  output logic [SLOT_W-1:0]   out_slot_index
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_RES  = 2'd2;

  logic [1:0]            phase_r, phase_nxt;
  logic [OP_W-1:0]       req_op_r, req_op_nxt;
  logic [KEY_BITS-1:0]   req_key_r, req_key_nxt;
  logic [VALUE_BITS-1:0] req_value_r, req_value_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [DATA_W-1:0]     out_read_value_r, out_read_value_nxt;
  logic [SLOT_W-1:0]     out_slot_index_r, out_slot_index_nxt;

  logic                  in_accept;
  logic                  can_commit;
  logic                  is_add, is_get, is_rmv;
  logic                  found;
  cell_cmd_t             cmd;

  logic [ENTRIES:0]      claim;
  logic [ENTRIES-1:0]    sel_vec;
  logic [ENTRIES-1:0]    valid_vec;
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];
  logic [VALUE_BITS-1:0] sel_value;
  logic [IDX_W-1:0]      sel_idx;
  logic [IDX_W+SLOT_W-1:0] sel_idx_ext;
  logic [STATUS_W-1:0]   res_status;

  // ---- control ----
  assign can_commit = (phase_r == PH_RES) && (!out_valid_r || !out_stall);
  assign in_stall   = !((phase_r == PH_IDLE) || can_commit);
  assign in_accept  = in_valid && !in_stall;

  assign is_add = (req_op_r == OP_ADD);
  assign is_get = (req_op_r == OP_GET);
  assign is_rmv = (req_op_r == OP_RMV);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: phase_nxt = in_accept ? PH_CMP : PH_IDLE;
      PH_CMP:  phase_nxt = PH_RES;
      PH_RES:  begin
        if (can_commit) begin
          phase_nxt = in_accept ? PH_CMP : PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    req_op_nxt    = req_op_r;
    req_key_nxt   = req_key_r;
    req_value_nxt = req_value_r;
    if (in_accept) begin
      req_op_nxt    = in_operation;
      req_key_nxt   = in_key[KEY_BITS-1:0];
      req_value_nxt = in_value[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    cmd.cmp_en    = (phase_r == PH_CMP);
    cmd.want_free = is_add;
    cmd.want_hit  = is_get || is_rmv;
    cmd.do_write  = can_commit && is_add;
    cmd.do_clear  = can_commit && is_rmv;
  end

  // ---- slot chain ----
  assign claim[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    kvst_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .req_key   (req_key_r),
      .req_value (req_value_r),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1]),
      .sel       (sel_vec[g]),
      .valid_q   (valid_vec[g]),
      .value_q   (cell_value[g])
    );
  end

  assign found = claim[ENTRIES];

  // one-hot select: OR together the chosen slot's value and number
  always_comb begin
    sel_value = '0;
    sel_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_vec[i]) begin
        sel_value = sel_value | cell_value[i];
        sel_idx   = sel_idx | IDX_W'(i);
      end
    end
  end

  assign sel_idx_ext = (IDX_W+SLOT_W)'(sel_idx);

  always_comb begin
    res_status = ST_MISSING;
    if (found) begin
      res_status = ST_OK;
    end else if (is_add) begin
      res_status = ST_FULL;
    end
  end

  // ---- result register ----
  always_comb begin
    out_valid_nxt      = out_valid_r;
    out_status_nxt     = out_status_r;
    out_read_value_nxt = out_read_value_r;
    out_slot_index_nxt = out_slot_index_r;
    if (can_commit) begin
      out_valid_nxt      = 1'b1;
      out_status_nxt     = res_status;
      out_read_value_nxt = (is_get && found) ? DATA_W'(sel_value) : '0;
      out_slot_index_nxt = found ? sel_idx_ext[SLOT_W-1:0] : '0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      req_op_r    <= OP_GET;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      req_op_r    <= req_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_key_r        <= req_key_nxt;
    req_value_r      <= req_value_nxt;
    out_status_r     <= out_status_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_slot_index_r <= out_slot_index_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_slot_index = out_slot_index_r;

  // ---- assertions ----
  a_sel_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("claim chain selected more than one slot");

  a_found_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RES) |-> (found == (sel_vec != '0)))
    else $error("found flag disagrees with slot select");

  a_add_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (can_commit && is_add && found) |=> (($past(sel_vec) & valid_vec) == $past(sel_vec)))
    else $error("add did not mark its slot valid");

  a_rmv_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (can_commit && is_rmv && found) |=> (($past(sel_vec) & valid_vec) == '0))
    else $error("remove did not free its slot");

  a_full_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (can_commit && !is_add) |-> (res_status != ST_FULL))
    else $error("table full reported for a non-add transaction");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for key_value_slot_table_top: directed and random add, get and
// remove transactions checked against a slot-by-slot table predictor.
// Depends on rtl/kvst_pkg.sv and rtl/key_value_slot_table_top.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kvst_pkg::*;

  localparam int N_SLOTS        = 32;
  localparam int KEY_W          = 64;
  localparam int VAL_W          = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int KEY_POOL       = 12;

  localparam logic [OP_W-1:0]   OP_NONE  = 2'd3;
  localparam logic [DATA_W-1:0] KEY_MASK = {DATA_W{1'b1}} >> (DATA_W - KEY_W);
  localparam logic [DATA_W-1:0] VAL_MASK = {DATA_W{1'b1}} >> (DATA_W - VAL_W);
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;
    logic [SLOT_W-1:0]   slot_index;
  } table_result_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation   = '0;
  logic [DATA_W-1:0]   in_key         = '0;
  logic [DATA_W-1:0]   in_value       = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_read_value;
  logic [SLOT_W-1:0]   out_slot_index;

  // Predictor copy of the table
  bit                slot_used [N_SLOTS];
  logic [DATA_W-1:0] slot_key  [N_SLOTS];
  logic [DATA_W-1:0] slot_val  [N_SLOTS];

  table_result_t pending_results[$];
  int            mismatch_count   = 0;
  int            sender_idle_pct  = 0;
  int            result_stall_pct = 0;
  int            quiet_cycles     = 0;
  int            hold_left        = 0;
  bit            hold_request     = 1'b0;

  key_value_slot_table_top #(
    .ENTRIES    (N_SLOTS),
    .KEY_BITS   (KEY_W),
    .VALUE_BITS (VAL_W)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_slot_index (out_slot_index)
  );

  always #2 clk = ~clk;

  function automatic table_result_t table_predict(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] key,
                                                  input logic [DATA_W-1:0] value);
    table_result_t     res;
    logic [DATA_W-1:0] k;
    int                hit;
    res = '{status: ST_MISSING, read_value: '0, slot_index: '0};
    k   = key & KEY_MASK;
    hit = -1;
    if (op == OP_ADD) begin
      res.status = ST_FULL;
      for (int i = 0; i < N_SLOTS; i++) begin
        if (!slot_used[i]) begin
          slot_used[i]   = 1'b1;
          slot_key[i]    = k;
          slot_val[i]    = value & VAL_MASK;
          res.status     = ST_OK;
          res.slot_index = i[SLOT_W-1:0];
          break;
        end
      end
    end else if (op == OP_GET || op == OP_RMV) begin
      // lowest-index valid slot with an exact key match; free slots never match
      for (int i = 0; i < N_SLOTS; i++) begin
        if (slot_used[i] && slot_key[i] == k) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        res.status     = ST_OK;
        res.slot_index = hit[SLOT_W-1:0];
        if (op == OP_GET) begin
          res.read_value = slot_val[hit];
        end else begin
          slot_used[hit] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] value);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_value     <= value;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(table_predict(op, key, value));
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    table_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", out_status, out_slot_index);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          mismatch_count++;
        end
        if (out_read_value !== exp_res.read_value) begin
          $error("read_value: expected %h, got %h", exp_res.read_value, out_read_value);
          mismatch_count++;
        end
        if (out_slot_index !== exp_res.slot_index) begin
          $error("slot_index: expected %0d, got %0d", exp_res.slot_index, out_slot_index);
          mismatch_count++;
        end
      end
    end
  end

  // Result-side stall; a long hold-off is counted here when requested
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < result_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    logic [DATA_W-1:0] mid_key;
    logic [DATA_W-1:0] dup_val;
    mid_key = 64'h5A5A_C3C3_0F0F_9669;
    dup_val = rand_word();
    send_item(OP_GET, '0, '0);             // empty table
    send_item(OP_RMV, ALL_ONES, ALL_ONES);
    send_item(OP_NONE, '0, '0);
    send_item(OP_ADD, '0, '0);
    send_item(OP_ADD, ALL_ONES, ALL_ONES);
    send_item(OP_ADD, mid_key, rand_word());
    send_item(OP_GET, ALL_ONES, '0);
    send_item(OP_GET, '0, ALL_ONES);
    send_item(OP_GET, ALL_ONES ^ 64'h1, '0);  // one bit off: no match
    send_item(OP_ADD, ALL_ONES, dup_val);     // duplicate key
    send_item(OP_GET, ALL_ONES, '0);
    send_item(OP_RMV, ALL_ONES, '0);
    send_item(OP_GET, ALL_ONES, '0);
    send_item(OP_RMV, ALL_ONES, '0);
    send_item(OP_GET, ALL_ONES, '0);          // stale key in free slots
    send_item(OP_ADD, 64'h8000_0000_0000_0000, 64'h1);
    send_item(OP_NONE, '0, ALL_ONES);
    send_item(OP_RMV, '0, '0);
    send_item(OP_RMV, '0, '0);
    send_item(OP_RMV, mid_key, '0);
    send_item(OP_RMV, 64'h8000_0000_0000_0000, '0);
  endtask

  task automatic test_table_full();
    logic [DATA_W-1:0] keys [N_SLOTS];
    for (int i = 0; i < N_SLOTS; i++) begin
      keys[i] = rand_word();
      send_item(OP_ADD, keys[i], rand_word());
    end
    send_item(OP_ADD, rand_word(), rand_word());
    send_item(OP_ADD, ALL_ONES, ALL_ONES);
    send_item(OP_GET, keys[N_SLOTS-1], '0);
    send_item(OP_RMV, keys[7], '0);
    keys[7] = rand_word();
    send_item(OP_ADD, keys[7], rand_word());
    for (int i = N_SLOTS - 1; i >= 0; i--) begin
      send_item(OP_RMV, keys[i], rand_word());
    end
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    logic [DATA_W-1:0] pool [KEY_POOL];
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] key;
    int                add_weight;
    int                pick;
    sender_idle_pct  = idle_pct;
    result_stall_pct = stall_pct;
    pool[0] = '0;
    pool[1] = ALL_ONES;
    for (int i = 2; i < KEY_POOL; i++) pool[i] = rand_word();
    for (int n = 0; n < count; n++) begin
      // alternate fill-heavy and drain-heavy stretches so the table swings to full and back
      add_weight = ((n / 64) % 2 == 0) ? 55 : 25;
      pick = $urandom_range(99);
      if (pick < add_weight)           op = OP_ADD;
      else if (pick < add_weight + 30) op = OP_GET;
      else if (pick < 97)              op = OP_RMV;
      else                             op = OP_NONE;
      key = ($urandom_range(3) != 0) ? pool[$urandom_range(KEY_POOL - 1)] : rand_word();
      send_item(op, key, rand_word());
    end
  endtask

  task automatic test_backpressure();
    sender_idle_pct  = 0;
    result_stall_pct = 0;
    @(posedge clk);
    hold_request = 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_item(($urandom_range(1) != 0) ? OP_ADD : OP_GET, rand_word(), rand_word());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random(170, 0, 0);
    test_random(170, 74, 0);
    test_random(170, 0, 74);
    test_backpressure();
    test_random(170, 37, 37);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
